/* sv/tta_pkg.sv */
// package for the top talker byte aggregator
// types, codes and fixed widths shared by the interfaces and the rtl
package tta_pkg;
	localparam int ADDR_W  = 32;
	localparam int TOTAL_W = 48;
	localparam int BYTES_W = 16;
	localparam int TOPC_W  = 5;
	localparam int RANK_W  = 4;
	localparam logic [TOPC_W-1:0] TOP_COUNT_RST = 5'd10;

	// command codes
	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_REPORT = 1'b1;

	// one table entry as kept in memory
	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [TOTAL_W-1:0] total;
	} entry_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SRC  = 5'b00010,
		ST_DST  = 5'b00100,
		ST_RPT  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;
endpackage

/* sv/tta_ifs.sv */
// channel interfaces for the top talker byte aggregator
// depends on tta_pkg for the field widths
interface tta_rec_if;
	logic                        valid;
	logic                        ready;
	logic                        cmd;
	logic [tta_pkg::ADDR_W-1:0]  source_address;
	logic [tta_pkg::ADDR_W-1:0]  dest_address;
	logic [tta_pkg::BYTES_W-1:0] byte_count;
	modport source (output valid, cmd, source_address, dest_address, byte_count, input ready);
	modport sink (input valid, cmd, source_address, dest_address, byte_count, output ready);
endinterface

interface tta_rpt_if;
	logic                        valid;
	logic                        ready;
	logic [tta_pkg::ADDR_W-1:0]  address;
	logic [tta_pkg::TOTAL_W-1:0] total_bytes;
	logic [tta_pkg::RANK_W-1:0]  rank;
	logic                        is_empty;
	logic                        table_overflowed;
	logic                        last;
	modport source (output valid, address, total_bytes, rank, is_empty, table_overflowed,
		last, input ready);
	modport sink (input valid, address, total_bytes, rank, is_empty, table_overflowed,
		last, output ready);
endinterface

interface tta_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [tta_pkg::TOPC_W-1:0] top_count;
	modport source (output valid, top_count, input ready);
	modport sink (input valid, top_count, output ready);
endinterface

/* sv/tta_ram.sv */
// generic single write port ram with registered read
// no dependencies
module tta_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/top_talker_byte_aggregator_unit.sv */
// a record does one linear table scan per address; a report of n words does one full scan per rank.
// scans read one table entry at a time through the single read port of the table ram.
// reset (arst_n low) empties the table, clears the drop flag and sets top_count to 10.
// the table ram itself is not cleared; only entries below the fill count are read.
module top_talker_byte_aggregator_unit #(
	parameter int TABLE_DEPTH = 256,
	parameter int TOP_MAX     = 16
) (
	input logic       clk,
	input logic       arst_n,
	tta_rec_if.sink   rec,
	tta_rpt_if.source rpt,
	tta_cfg_if.sink   cfg
);
	import tta_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int NW = $clog2(TOP_MAX + 1);
	localparam int EW = ADDR_W + TOTAL_W;

	state_t              state_q;
	logic [TOPC_W-1:0]   top_count_q;
	logic [CW-1:0]       count_q;
	logic                ovf_q;
	logic [CW-1:0]       idx_q;
	logic                v_s1;
	logic [IW-1:0]       idx_s1;
	logic [ADDR_W-1:0]   src_q;
	logic [ADDR_W-1:0]   dst_q;
	logic [BYTES_W-1:0]  bytes_q;
	logic [NW-1:0]       n_q;
	logic [NW-1:0]       k_q;
	entry_t              prev_q;
	logic                have_prev_q;
	entry_t              best_q;
	logic                have_best_q;
	entry_t              out_q;
	logic [RANK_W-1:0]   rank_q;
	logic                empty_q;
	logic                ovf_out_q;
	logic                last_q;

	entry_t              rd_entry;
	logic [EW-1:0]       rd_data;
	logic                we;
	logic [IW-1:0]       waddr;
	entry_t              wentry;
	logic [ADDR_W-1:0]   key;
	logic                crediting;
	logic                hit;
	logic                scan_end;
	logic                issue;
	logic [TOTAL_W:0]    sum;
	logic [TOTAL_W-1:0]  sat;
	logic                eligible;
	logic                beats_best;
	logic                last_pick;
	logic [NW-1:0]       n_lim;

	// table memory
	tta_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wentry),
		.raddr (idx_q[IW-1:0]),
		.rdata (rd_data)
	);
	assign rd_entry = entry_t'(rd_data);

	// scan control and saturating credit
	always_comb begin
		crediting = (state_q == ST_SRC) || (state_q == ST_DST);
		key       = (state_q == ST_SRC) ? src_q : dst_q;
		hit       = crediting && v_s1 && (rd_entry.addr == key);
		scan_end  = (idx_q >= count_q) && !v_s1;
		issue     = (crediting || state_q == ST_RPT) && (idx_q < count_q) && !hit;
		sum       = {1'b0, rd_entry.total} + (TOTAL_W+1)'(bytes_q);
		sat       = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
		we        = 1'b0;
		waddr     = idx_s1;
		wentry    = '{addr: key, total: sat};
		if (hit) begin
			we = 1'b1;
		end else if (crediting && scan_end && (count_q < CW'(TABLE_DEPTH))) begin
			we     = 1'b1;
			waddr  = count_q[IW-1:0];
			wentry = '{addr: key, total: TOTAL_W'(bytes_q)};
		end
	end

	// ranking: candidate must rank below the previous pick and above the best so far
	always_comb begin
		eligible = !have_prev_q || (prev_q.total > rd_entry.total) ||
			((prev_q.total == rd_entry.total) && (prev_q.addr < rd_entry.addr));
		beats_best = !have_best_q || (rd_entry.total > best_q.total) ||
			((rd_entry.total == best_q.total) && (rd_entry.addr < best_q.addr));
		last_pick = (k_q + NW'(1)) == n_q;
	end

	// report length: top_count clamped to 1..TOP_MAX and to the fill count
	always_comb begin
		if (top_count_q == '0) begin
			n_lim = NW'(1);
		end else if (int'(top_count_q) > TOP_MAX) begin
			n_lim = NW'(TOP_MAX);
		end else begin
			n_lim = NW'(top_count_q);
		end
		if (int'(n_lim) > int'(count_q)) begin
			n_lim = NW'(count_q);
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_count_q <= TOP_COUNT_RST;
		end else if (cfg.valid && cfg.ready) begin
			top_count_q <= cfg.top_count;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
			have_prev_q <= 1'b0;
			have_best_q <= 1'b0;
			k_q         <= '0;
			n_q         <= '0;
		end else begin
			// entry index of the read in flight
			idx_s1 <= idx_q[IW-1:0];
			case (state_q)
				ST_IDLE: begin
					v_s1 <= 1'b0;
					idx_q <= '0;
					if (rec.valid && rec.ready) begin
						if (rec.cmd == CMD_RECORD) begin
							state_q <= ST_SRC;
						end else if (count_q == '0) begin
							state_q <= ST_EMIT;
						end else begin
							n_q         <= n_lim;
							k_q         <= '0;
							have_prev_q <= 1'b0;
							have_best_q <= 1'b0;
							state_q     <= ST_RPT;
						end
					end
				end
				ST_SRC, ST_DST: begin
					if (hit || scan_end) begin
						if (!hit) begin
							if (count_q < CW'(TABLE_DEPTH)) begin
								count_q <= count_q + CW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end
						v_s1  <= 1'b0;
						idx_q <= '0;
						state_q <= (state_q == ST_SRC) ? ST_DST : ST_IDLE;
					end else begin
						v_s1 <= issue;
						if (issue) begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				ST_RPT: begin
					if (v_s1 && eligible && beats_best) begin
						have_best_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_EMIT;
					end
					v_s1 <= issue;
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_EMIT: begin
					if (rpt.ready) begin
						if (last_q) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							have_prev_q <= 1'b1;
							have_best_q <= 1'b0;
							k_q     <= k_q + NW'(1);
							idx_q   <= '0;
							v_s1    <= 1'b0;
							state_q <= ST_RPT;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && rec.valid) begin
			src_q   <= rec.source_address;
			dst_q   <= rec.dest_address;
			bytes_q <= rec.byte_count;
			out_q     <= '0;
			rank_q    <= '0;
			empty_q   <= 1'b1;
			ovf_out_q <= ovf_q;
			last_q    <= 1'b1;
		end
		if (state_q == ST_RPT && v_s1 && eligible && beats_best) begin
			best_q <= rd_entry;
		end
		if (state_q == ST_RPT && scan_end) begin
			out_q     <= best_q;
			rank_q    <= RANK_W'(k_q);
			empty_q   <= 1'b0;
			ovf_out_q <= ovf_q;
			last_q    <= last_pick;
		end
		if (state_q == ST_EMIT && rpt.ready) begin
			prev_q <= out_q;
		end
	end

	// ports
	assign rec.ready            = (state_q == ST_IDLE);
	assign cfg.ready            = 1'b1;
	assign rpt.valid            = (state_q == ST_EMIT);
	assign rpt.address          = out_q.addr;
	assign rpt.total_bytes      = out_q.total;
	assign rpt.rank             = rank_q;
	assign rpt.is_empty         = empty_q;
	assign rpt.table_overflowed = ovf_out_q;
	assign rpt.last             = last_q;

`ifndef SYNTHESIS
	// fill count never passes the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("fill count beyond table depth");
	// a report word is never shown while records are taken
	a_emit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rpt.valid |-> !rec.ready)
		else $error("report word overlaps record intake");
	// the final word of a report empties the table
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(rpt.valid && rpt.ready && rpt.last) |=> (count_q == '0) && !ovf_q)
		else $error("table not cleared after report");
	// a non empty report never carries more words than the clamped report length allows
	a_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(rpt.valid && !rpt.is_empty) |-> (k_q < n_q))
		else $error("rank beyond report length");
`endif
endmodule
